// ----- rtl/lidar_scan_to_occupancy_grid_top_defines.svh -----
// Assertion macros shared by the occupancy grid RTL.
// Included by the modules that carry concurrent assertions; needs no other file.
`ifndef LIDAR_SCAN_TO_OCCUPANCY_GRID_TOP_DEFINES_SVH
`define LIDAR_SCAN_TO_OCCUPANCY_GRID_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSOG_ASSERT_NOW(label, ck, rstn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("lsog: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSOG_ASSERT_NEXT(label, ck, rstn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("lsog: next-cycle check failed");

`endif

// ----- rtl/lsog_pkg.sv -----
// Shared constants, types and tables of the occupancy grid block.
// Used by every module of the block; depends on nothing.
package lsog_pkg;

	localparam int HALF_CELLS      = 64;
	localparam int BEAM_INDEX_BITS = 12;
	localparam int CORDIC_STAGES   = 16;

	localparam int GRID_SIDE   = 2 * HALF_CELLS;
	localparam int CELL_BITS   = $clog2(GRID_SIDE);
	localparam int ADDR_BITS   = 2 * CELL_BITS;
	localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;

	localparam int INV_GAIN_Q16 = 39797;
	localparam int XY_W         = 36;
	localparam int Z_W          = 34;
	localparam int CS_W         = 10;
	localparam int OFS_W        = (CELL_BITS + 13 > 20) ? CELL_BITS + 13 : 20;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef enum logic [1:0] {
		ST_MARKED   = 2'd0,
		ST_REJECTED = 2'd1,
		ST_OUTSIDE  = 2'd2,
		ST_READ     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_RANGE_MIN   = 3'd0,
		REG_RANGE_MAX   = 3'd1,
		REG_ANGLE_START = 3'd2,
		REG_ANGLE_STEP  = 3'd3,
		REG_CELL_SIZE   = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [15:0]        rng_lo;
		logic [15:0]        rng_hi;
		logic [15:0]        angle_start;
		logic [15:0]        angle_step;
		logic [CS_W-1:0]    cell_size;   // never zero
	} cfg_t;

	typedef struct packed {
		status_t                status;
		logic [6:0]             out_x;
		logic [6:0]             out_y;
		logic [ADDR_BITS-1:0]   addr;
		logic                   beyond;
	} qent_t;

endpackage

// ----- rtl/lsog_front.sv -----
// Front end: accepts items, checks the range window, rotates the beam with a
// pipelined CORDIC and finds the cell with a pipelined divider. Uses lsog_pkg.
module lsog_front import lsog_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  hold,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_kind,
	input  logic [11:0]           in_beam_index,
	input  logic [15:0]           in_range,
	input  logic [6:0]            in_read_x,
	input  logic [6:0]            in_read_y,
	input  logic                  push_ok,
	output logic                  push,
	output qent_t                 push_data
);

	typedef struct packed {
		logic       vld;
		status_t    st;
		logic [6:0] rx;
		logic [6:0] ry;
		logic       beyond;
	} tag_t;

	localparam int NDIV = CELL_BITS;

	logic en;
	tag_t tag_in;
	logic [BEAM_INDEX_BITS-1:0] idx;

	tag_t        tag_s1;
	logic [15:0] ang_prod_s1;
	logic [31:0] r_prod_s1;

	tag_t                   tag_s2;
	logic signed [XY_W-1:0] x_s2;
	logic signed [Z_W-1:0]  z_s2;

	tag_t                   cor_tag_s [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] cor_x_s   [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] cor_y_s   [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]  cor_z_s   [CORDIC_STAGES+1];

	tag_t                 div_tag_s [NDIV+1];
	logic [OFS_W-1:0]     div_rx_s  [NDIV+1];
	logic [OFS_W-1:0]     div_ry_s  [NDIV+1];
	logic [CELL_BITS-1:0] div_qx_s  [NDIV+1];
	logic [CELL_BITS-1:0] div_qy_s  [NDIV+1];

	tag_t tail;

	assign tail     = div_tag_s[NDIV];
	assign en       = !tail.vld || push_ok;
	assign in_ready = en && !hold;
	assign idx      = BEAM_INDEX_BITS'(in_beam_index);

	always_comb begin
		tag_in.vld    = in_valid && in_ready;
		tag_in.rx     = in_read_x;
		tag_in.ry     = in_read_y;
		tag_in.beyond = (32'(in_read_x) >= GRID_SIDE) || (32'(in_read_y) >= GRID_SIDE);
		if (in_kind) begin
			tag_in.st = ST_READ;
		end else if (in_range < cfg.rng_lo || in_range > cfg.rng_hi) begin
			tag_in.st = ST_REJECTED;
		end else begin
			tag_in.st = ST_MARKED;
		end
	end

	// Stage 1: the two products. Only the valid flag is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.vld <= 1'b0;
		end else if (en) begin
			tag_s1      <= tag_in;
			ang_prod_s1 <= 16'(32'(idx) * 32'(cfg.angle_step));
			r_prod_s1   <= 32'(in_range) * 32'(INV_GAIN_Q16);
		end
	end

	// Stage 2: beam angle, folded into the right half plane.
	logic [15:0]            ang;
	logic signed [16:0]     sa;
	logic                   fold;
	logic signed [16:0]     sa_f;
	logic signed [XY_W-1:0] x_abs;

	always_comb begin
		ang   = cfg.angle_start + ang_prod_s1;
		sa    = {ang[15], ang};
		fold  = (sa > 17'sd16384) || (sa < -17'sd16384);
		sa_f  = sa;
		if (fold) begin
			sa_f = (sa > 17'sd0) ? sa - 17'sd32768 : sa + 17'sd32768;
		end
		x_abs = signed'(XY_W'(r_prod_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2.vld <= 1'b0;
		end else if (en) begin
			tag_s2 <= tag_s1;
			x_s2   <= fold ? -x_abs : x_abs;
			z_s2   <= Z_W'(sa_f) <<< 16;
		end
	end

	assign cor_tag_s[0] = tag_s2;
	assign cor_x_s[0]   = x_s2;
	assign cor_y_s[0]   = '0;
	assign cor_z_s[0]   = z_s2;

	// CORDIC rotation, one micro-rotation per stage.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [Z_W-1:0] at;
		assign at = signed'(Z_W'(ATAN_TURN32[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_tag_s[i+1].vld <= 1'b0;
			end else if (en) begin
				cor_tag_s[i+1] <= cor_tag_s[i];
				if (cor_z_s[i] >= 0) begin
					cor_x_s[i+1] <= cor_x_s[i] - (cor_y_s[i] >>> i);
					cor_y_s[i+1] <= cor_y_s[i] + (cor_x_s[i] >>> i);
					cor_z_s[i+1] <= cor_z_s[i] - at;
				end else begin
					cor_x_s[i+1] <= cor_x_s[i] + (cor_y_s[i] >>> i);
					cor_y_s[i+1] <= cor_y_s[i] - (cor_x_s[i] >>> i);
					cor_z_s[i+1] <= cor_z_s[i] + at;
				end
			end
		end
	end

	// Offset stage: shift the grid origin to zero; cell index then lies in
	// [0, GRID_SIDE) exactly when the offset coordinate is in [0, 2*half).
	logic signed [OFS_W-1:0] hc, lim, xo, yo;
	tag_t ct;
	tag_t ofs_tag;

	assign ct  = cor_tag_s[CORDIC_STAGES];
	assign hc  = signed'(OFS_W'(32'(HALF_CELLS) * 32'(cfg.cell_size)));
	assign lim = hc + hc;
	assign xo  = signed'(OFS_W'(cor_x_s[CORDIC_STAGES] >>> 16)) + hc;
	assign yo  = signed'(OFS_W'(cor_y_s[CORDIC_STAGES] >>> 16)) + hc;

	always_comb begin
		ofs_tag = ct;
		if (ct.st == ST_MARKED && (xo < 0 || xo >= lim || yo < 0 || yo >= lim)) begin
			ofs_tag.st = ST_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_tag_s[0].vld <= 1'b0;
		end else if (en) begin
			div_tag_s[0] <= ofs_tag;
			div_rx_s[0]  <= unsigned'(xo);
			div_ry_s[0]  <= unsigned'(yo);
			div_qx_s[0]  <= '0;
			div_qy_s[0]  <= '0;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < NDIV; j++) begin : g_div
		logic [OFS_W-1:0] dsh;
		assign dsh = OFS_W'(cfg.cell_size) << (NDIV - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_tag_s[j+1].vld <= 1'b0;
			end else if (en) begin
				div_tag_s[j+1] <= div_tag_s[j];
				if (div_rx_s[j] >= dsh) begin
					div_rx_s[j+1] <= div_rx_s[j] - dsh;
					div_qx_s[j+1] <= {div_qx_s[j][CELL_BITS-2:0], 1'b1};
				end else begin
					div_rx_s[j+1] <= div_rx_s[j];
					div_qx_s[j+1] <= {div_qx_s[j][CELL_BITS-2:0], 1'b0};
				end
				if (div_ry_s[j] >= dsh) begin
					div_ry_s[j+1] <= div_ry_s[j] - dsh;
					div_qy_s[j+1] <= {div_qy_s[j][CELL_BITS-2:0], 1'b1};
				end else begin
					div_ry_s[j+1] <= div_ry_s[j];
					div_qy_s[j+1] <= {div_qy_s[j][CELL_BITS-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		push             = tail.vld && push_ok;
		push_data.status = tail.st;
		push_data.beyond = tail.beyond;
		push_data.out_x  = '0;
		push_data.out_y  = '0;
		push_data.addr   = {div_qy_s[NDIV], div_qx_s[NDIV]};
		case (tail.st)
			ST_MARKED: begin
				push_data.out_x = 7'(div_qx_s[NDIV]);
				push_data.out_y = 7'(div_qy_s[NDIV]);
			end
			ST_READ: begin
				push_data.out_x = tail.rx;
				push_data.out_y = tail.ry;
				push_data.addr  = {CELL_BITS'(tail.ry), CELL_BITS'(tail.rx)};
			end
			default: begin
				push_data.out_x = '0;
				push_data.out_y = '0;
			end
		endcase
	end

endmodule

// ----- rtl/lsog_queue.sv -----
// Short queue that decouples the front end from the grid back end.
// Uses lsog_pkg and the assertion macros header.
`include "lidar_scan_to_occupancy_grid_top_defines.svh"
module lsog_queue import lsog_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  push_ok,
	output logic  pop_valid,
	input  logic  pop,
	output qent_t pop_data
);

	qent_t              buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wp_q, rp_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign push_ok   = (cnt_q < QCNT_W'(QUEUE_DEPTH)) || pop;
	assign pop_valid = cnt_q != '0;
	assign pop_data  = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	`LSOG_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`LSOG_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, cnt_q != '0)
	`LSOG_ASSERT_NEXT(a_drain, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

// ----- rtl/lsog_back.sv -----
// Back end: holds the occupancy bit grid, marks and reads cells, and drives
// the result register. Uses lsog_pkg and the assertion macros header.
`include "lidar_scan_to_occupancy_grid_top_defines.svh"
module lsog_back import lsog_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  qent_t      q_data,
	output logic       pop,
	output logic       clearing,
	output logic       out_valid,
	input  logic       out_ready,
	output status_t    out_status,
	output logic [6:0] out_x,
	output logic [6:0] out_y,
	output logic       out_occupied
);

	logic                 grid_q [GRID_CELLS];
	logic                 rd_q;
	logic                 clearing_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 out_vld_q;
	qent_t                res_q;

	assign clearing = clearing_q;
	assign pop      = q_valid && !clearing_q && (!out_vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			grid_q[clr_addr_q] <= 1'b0;
		end else if (pop && q_data.status == ST_MARKED) begin
			grid_q[q_data.addr] <= 1'b1;
		end
		if (pop) begin
			rd_q  <= grid_q[q_data.addr];
			res_q <= q_data;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_status = res_q.status;
	assign out_x      = res_q.out_x;
	assign out_y      = res_q.out_y;

	always_comb begin
		case (res_q.status)
			ST_MARKED: out_occupied = 1'b1;
			ST_READ:   out_occupied = rd_q && !res_q.beyond;
			default:   out_occupied = 1'b0;
		endcase
	end

	`LSOG_ASSERT_NOW(a_no_pop_clearing, clk, arst_n, clearing_q, !pop)
	`LSOG_ASSERT_NEXT(a_pop_shows, clk, arst_n, pop, out_vld_q)
	`LSOG_ASSERT_NOW(a_reject_zero, clk, arst_n, out_vld_q && res_q.status == ST_REJECTED,
		out_x == '0 && out_y == '0 && !out_occupied)

endmodule

// ----- rtl/lidar_scan_to_occupancy_grid_top.sv -----
// Lidar beam endpoints into an occupancy grid. Path from input transfer to result:
// 2 product/angle stages, 16 CORDIC stages, 1 offset stage, 7 divider stages, queue,
// result register. Throughput: one item per cycle when the output is not stalled, set
// by the fully pipelined CORDIC and divider and a grid read and mark in the same cycle.
// Reset is asynchronous, active low; afterwards a clearing pass over every cell writes
// the grid to zero while s_tready stays low (config writes are taken).
module lidar_scan_to_occupancy_grid_top import lsog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port; index follows reg_index_t.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // beam_index[11:0], range_mm[27:12], read_x[34:28],
	                               // read_y[41:35], zero fill [47:42]
	input  logic [0:0]  s_tuser,   // kind[0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // cell_x[6:0], cell_y[13:7], cell_occupied[14], zero [15]
	output logic [1:0]  m_tuser    // status[1:0]
);

	cfg_t    cfg_q;
	logic    push, push_ok, pop, q_valid, clearing;
	qent_t   push_data, q_data;
	status_t out_status;
	logic [6:0] out_x, out_y;
	logic    out_occupied;

	// Registers must be written by the user only while the block is idle, so no shadowing is
	// needed; the block itself does not enforce this. A cell size of zero is stored as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rng_lo      <= 16'd100;
			cfg_q.rng_hi      <= 16'd30000;
			cfg_q.angle_start <= 16'h8000;
			cfg_q.angle_step  <= 16'd64;
			cfg_q.cell_size   <= CS_W'(50);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_RANGE_MIN:   cfg_q.rng_lo      <= cfg_data;
				REG_RANGE_MAX:   cfg_q.rng_hi      <= cfg_data;
				REG_ANGLE_START: cfg_q.angle_start <= cfg_data;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data;
				REG_CELL_SIZE: begin
					cfg_q.cell_size <= (cfg_data[CS_W-1:0] == '0) ? CS_W'(1)
						: cfg_data[CS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: classify, rotate, find the cell; one item per cycle unless stalled.
	lsog_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.hold          (clearing),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_kind       (s_tuser[0]),
		.in_beam_index (s_tdata[11:0]),
		.in_range      (s_tdata[27:12]),
		.in_read_x     (s_tdata[34:28]),
		.in_read_y     (s_tdata[41:35]),
		.push_ok       (push_ok),
		.push          (push),
		.push_data     (push_data)
	);

	// The queue lets the front keep transferring while a result waits downstream.
	lsog_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ok   (push_ok),
		.pop_valid (q_valid),
		.pop       (pop),
		.pop_data  (q_data)
	);

	// Back end: grid memory access and the result register.
	lsog_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.clearing     (clearing),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (out_status),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_occupied (out_occupied)
	);

	assign m_tuser = out_status;
	assign m_tdata = {1'b0, out_occupied, out_y, out_x};

endmodule

// ----- dv/lsog_checker.sv -----
// Result checker for the occupancy grid block: predicts each result from accepted inputs.
// Depends on lsog_pkg for status and register index types.
module lsog_checker import lsog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t    status;
		logic [6:0] cx;
		logic [6:0] cy;
		logic       occ;
	} cell_result_t;

	logic [15:0] rmin, rmax, astart, astep;
	logic [9:0]  csize;
	bit grid_occ [GRID_CELLS];
	cell_result_t expected_cells [$];

	assign pending = expected_cells.size();

	// Floor shift of a signed value.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint floor_div(longint v, longint d);
		longint q;
		q = v / d;
		if ((v % d) != 0 && v < 0)
			q--;
		return q;
	endfunction

	function automatic cell_result_t mark_beam(logic [11:0] idx, logic [15:0] rng);
		cell_result_t r;
		logic [15:0] ang;
		int sa;
		longint x, y, z, nx, ny, d, cx, cy;
		r = '0;
		if (rng < rmin || rng > rmax) begin
			r.status = ST_REJECTED;
			return r;
		end
		ang = astart + idx * astep;
		sa = $signed(ang);
		x = longint'(rng) * INV_GAIN_Q16;
		y = 0;
		if (sa > 16384 || sa < -16384) begin
			x = -x;
			sa = (sa > 0) ? sa - 32768 : sa + 32768;
		end
		z = longint'(sa) * 65536;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i);
				ny = y + floor_shr(x, i);
				z -= longint'(ATAN_TURN32[i]);
			end else begin
				nx = x + floor_shr(y, i);
				ny = y - floor_shr(x, i);
				z += longint'(ATAN_TURN32[i]);
			end
			x = nx;
			y = ny;
		end
		d = longint'(csize == 0 ? 10'd1 : csize) * 65536;
		cx = floor_div(x, d) + HALF_CELLS;
		cy = floor_div(y, d) + HALF_CELLS;
		if (cx < 0 || cx >= GRID_SIDE || cy < 0 || cy >= GRID_SIDE) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		grid_occ[cy * GRID_SIDE + cx] = 1'b1;
		r.status = ST_MARKED;
		r.cx = cx[6:0];
		r.cy = cy[6:0];
		r.occ = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t got, want;
		if (!arst_n) begin
			rmin <= 16'd100;
			rmax <= 16'd30000;
			astart <= 16'h8000;
			astep <= 16'd64;
			csize <= 10'd50;
			foreach (grid_occ[i])
				grid_occ[i] = 1'b0;
			expected_cells.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_RANGE_MIN:   rmin <= cfg_data;
					REG_RANGE_MAX:   rmax <= cfg_data;
					REG_ANGLE_START: astart <= cfg_data;
					REG_ANGLE_STEP:  astep <= cfg_data;
					REG_CELL_SIZE:   csize <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					want = '0;
					want.status = ST_READ;
					want.cx = s_tdata[34:28];
					want.cy = s_tdata[41:35];
					want.occ = grid_occ[s_tdata[41:35] * GRID_SIDE + s_tdata[34:28]];
				end else begin
					want = mark_beam(s_tdata[11:0], s_tdata[27:12]);
				end
				expected_cells.insert(expected_cells.size(), want);
			end
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.cx = m_tdata[6:0];
				got.cy = m_tdata[13:7];
				got.occ = m_tdata[14];
				if (expected_cells.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_cells.pop_front();
					if (got !== want || m_tdata[15] !== 1'b0) begin
						$display("%0t: result mismatch, expected st=%0d x=%0d y=%0d occ=%0d, actual st=%0d x=%0d y=%0d occ=%0d",
							$time, want.status, want.cx, want.cy, want.occ,
							got.status, got.cx, got.cy, got.occ);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- dv/tb_top.sv -----
// Top of the occupancy grid testbench: clock, reset, stimulus, configuration and verdict.
// Depends on lsog_pkg, the block's top module and lsog_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lsog_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending;

	// Ranges of the beams of the current phase are kept near the grid's reach so that
	// most beams land inside the grid; this scale follows the configured cell size.
	int reach_mm;

	always #10 clk = ~clk;

	lidar_scan_to_occupancy_grid_top dut (.*);

	lsog_checker checker_inst (.*);

	// The receiver stalls for a random number of cycles before each result, except in
	// phases where the stall is switched off, so that back-to-back transfers are seen too.
	bit sink_busy = 1'b1;
	initial begin
		int wait_cycles;
		forever begin
			@(posedge clk);
			wait_cycles = sink_busy ? $urandom_range(0, 15) : 0;
			if (wait_cycles > 0 && m_tready) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!m_tready) begin
				m_tready <= 1'b1;
			end else begin
				while (!m_tvalid) @(posedge clk);
			end
		end
	end

	bit source_busy = 1'b1;

	// Send one item; the valid stays high across back-to-back items without gaps.
	task automatic send_item(bit is_read, logic [11:0] idx, logic [15:0] rng,
		logic [6:0] rx, logic [6:0] ry);
		int gap;
		gap = source_busy ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_read;
		s_tdata <= {6'd0, ry, rx, rng, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		s_tdata <= 48'({$urandom, $urandom});
		s_tuser <= 1'b0;
	endtask

	// Let the block drain before a register write: every result back, then pipeline slack.
	task automatic drain();
		end_burst();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CELL_SIZE)
			reach_mm = ((value[9:0] == 0) ? 1 : value[9:0]) * HALF_CELLS * 3 / 2;
	endtask

	task automatic random_beam();
		int rng;
		if ($urandom_range(0, 9) == 0)
			rng = $urandom_range(0, 65535);
		else
			rng = $urandom_range(0, reach_mm > 65535 ? 65535 : reach_mm);
		send_item(1'b0, 12'($urandom), 16'(rng), 7'($urandom), 7'($urandom));
	endtask

	task automatic random_read();
		send_item(1'b1, 12'($urandom), 16'($urandom), 7'($urandom), 7'($urandom));
	endtask

	// One random phase: mostly beams, with reads spread in to sample the grid.
	task automatic random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0)
				random_read();
			else
				random_beam();
		end
		drain();
	endtask

	initial begin
		reach_mm = 50 * HALF_CELLS * 3 / 2;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset settings: range extremes, window edges, angle extremes,
		// reads of unwritten and just-marked cells, read coordinates at their extremes.
		send_item(1'b0, 12'd0, 16'd0, 7'd0, 7'd0);
		send_item(1'b0, 12'd0, 16'd99, 7'd0, 7'd0);
		send_item(1'b0, 12'd0, 16'd100, 7'd0, 7'd0);
		send_item(1'b0, 12'd0, 16'd30000, 7'd0, 7'd0);
		send_item(1'b0, 12'd0, 16'd30001, 7'd0, 7'd0);
		send_item(1'b0, 12'd0, 16'd65535, 7'd0, 7'd0);
		send_item(1'b0, 12'd4095, 16'd1000, 7'd0, 7'd0);
		send_item(1'b0, 12'd256, 16'd1000, 7'd0, 7'd0);
		send_item(1'b0, 12'd512, 16'd2000, 7'd0, 7'd0);
		send_item(1'b0, 12'd768, 16'd3100, 7'd0, 7'd0);
		send_item(1'b1, 12'd0, 16'd0, 7'd0, 7'd0);
		send_item(1'b1, 12'd4095, 16'd65535, 7'd127, 7'd127);
		send_item(1'b1, 12'd0, 16'd0, 7'd44, 7'd64);
		send_item(1'b1, 12'd0, 16'd0, 7'd64, 7'd44);
		drain();

		// Inverted window rejects everything; zero cell size counts as one millimetre.
		write_reg(REG_RANGE_MIN, 16'd5000);
		write_reg(REG_RANGE_MAX, 16'd10);
		send_item(1'b0, 12'd3, 16'd1000, 7'd0, 7'd0);
		send_item(1'b0, 12'd3, 16'd5000, 7'd0, 7'd0);
		drain();
		write_reg(REG_RANGE_MIN, 16'd0);
		write_reg(REG_RANGE_MAX, 16'hFFFF);
		write_reg(REG_CELL_SIZE, 16'd0);
		write_reg(REG_ANGLE_START, 16'h7FFF);
		write_reg(REG_ANGLE_STEP, 16'h8000);
		send_item(1'b0, 12'd0, 16'd0, 7'd0, 7'd0);
		send_item(1'b0, 12'd1, 16'd50, 7'd0, 7'd0);
		send_item(1'b0, 12'd2, 16'd63, 7'd0, 7'd0);
		send_item(1'b0, 12'd4095, 16'd64, 7'd0, 7'd0);
		drain();

		// Random phases across settings, the extremes among them.
		write_reg(REG_CELL_SIZE, 16'd1000);
		write_reg(REG_ANGLE_START, 16'h8000);
		write_reg(REG_ANGLE_STEP, 16'h7FFF);
		random_phase(120);
		write_reg(REG_CELL_SIZE, 16'd1);
		write_reg(REG_ANGLE_STEP, 16'd1);
		write_reg(REG_ANGLE_START, 16'd0);
		random_phase(120);
		sink_busy = 1'b0;
		source_busy = 1'b0;
		write_reg(REG_CELL_SIZE, 16'd1023);
		write_reg(REG_ANGLE_STEP, 16'hFFC0);
		random_phase(120);
		sink_busy = 1'b1;
		source_busy = 1'b1;
		for (int phase = 0; phase < 5; phase++) begin
			write_reg(REG_RANGE_MIN, 16'($urandom_range(0, 300)));
			write_reg(REG_RANGE_MAX, 16'($urandom_range(20000, 65535)));
			write_reg(REG_ANGLE_START, 16'($urandom));
			write_reg(REG_ANGLE_STEP, 16'($urandom));
			write_reg(REG_CELL_SIZE, 16'($urandom_range(1, 1023)));
			source_busy = phase[0];
			random_phase(130);
		end
		source_busy = 1'b1;

		// Final sweep reads back 60 random cells at the last settings.
		for (int n = 0; n < 60; n++)
			random_read();
		end_burst();
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Timeout: room for the clearing pass and about 1100 items, several times over.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
